/* rtl/tcw_pkg.sv */
// Shared types, codes and constants of the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int ROWS_N_DEF = 25;
  localparam int COLS_N_DEF = 80;

  // Input mode codes.
  localparam logic [2:0] MODE_STRING = 3'd0;
  localparam logic [2:0] MODE_CLEAR  = 3'd1;
  localparam logic [2:0] MODE_COLOR  = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_RAW    = 3'd4;

  // Escape parser phases.
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_SLASH = 2'd1;
  localparam logic [1:0] ESC_C     = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam logic [7:0]  COLOR_RESET = 8'h07;
  localparam logic [15:0] BLANK_RESET = 16'h0720;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_PRINT,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_EMIT,
    BK_SCROLL,
    BK_CLEAR,
    BK_READ
  } back_state_t;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    op_t        op;
    logic       two;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] color;
    logic [1:0] esc;
    logic [4:0] rrow;
    logic [6:0] rcol;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/tcw_front.sv */
// Front part: accepts items, runs the escape parser and turns items into commands.
`timescale 1ns / 1ps
`default_nettype none
module tcw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_mode,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_first_of_string,
  input  wire logic          in_last_of_string,
  input  wire logic [7:0]    in_color_value,
  input  wire logic [4:0]    in_read_row,
  input  wire logic [6:0]    in_read_col,
  input  wire logic          q_full,
  input  wire logic          init_busy,
  output logic               push,
  output tcw_pkg::cmd_t      cmd
);
  import tcw_pkg::*;

  logic [7:0] color_r, color_nxt;
  logic [7:0] saved_r, saved_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic [1:0] phase;

  assign in_ready = !q_full && !init_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    color_nxt = color_r;
    saved_nxt = saved_r;
    esc_nxt   = esc_r;
    phase     = esc_r;
    cmd.op    = OP_NOP;
    cmd.two   = 1'b0;
    cmd.ch0   = in_char_code;
    cmd.ch1   = in_char_code;
    cmd.rrow  = in_read_row;
    cmd.rcol  = in_read_col;
    case (in_mode)
      MODE_STRING: begin
        if (in_first_of_string) begin
          saved_nxt = color_r;
          phase     = ESC_NONE;
        end
        esc_nxt = ESC_NONE;
        if (phase == ESC_C) begin
          if (in_char_code inside {[CH_0:CH_9]}) begin
            color_nxt = {4'h0, in_char_code[3:0]};
          end else if (in_char_code inside {[CH_A:CH_F]}) begin
            color_nxt = 8'(in_char_code[3:0]) + 8'd9;
          end else if (in_char_code == CH_R) begin
            color_nxt = saved_nxt;
          end
        end else if (phase == ESC_SLASH && in_char_code == CH_C) begin
          if (in_last_of_string) begin
            cmd.op  = OP_PRINT;
            cmd.two = 1'b1;
            cmd.ch0 = CH_BSL;
            cmd.ch1 = CH_C;
          end else begin
            esc_nxt = ESC_C;
          end
        end else if (phase == ESC_SLASH) begin
          // The held backslash prints, then this byte is parsed afresh.
          cmd.op  = OP_PRINT;
          cmd.ch0 = CH_BSL;
          if (in_char_code == CH_BSL && !in_last_of_string) begin
            esc_nxt = ESC_SLASH;
          end else begin
            cmd.two = 1'b1;
          end
        end else begin
          if (in_char_code == CH_BSL && !in_last_of_string) begin
            esc_nxt = ESC_SLASH;
          end else begin
            cmd.op = OP_PRINT;
          end
        end
      end
      MODE_CLEAR: cmd.op = OP_CLEAR;
      MODE_COLOR: color_nxt = in_color_value;
      MODE_READ:  cmd.op = OP_READ;
      MODE_RAW:   cmd.op = OP_PRINT;
      default:    cmd.op = OP_NOP;
    endcase
    cmd.color = color_nxt;
    cmd.esc   = esc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RESET;
      saved_r <= COLOR_RESET;
      esc_r   <= ESC_NONE;
    end else if (push) begin
      color_r <= color_nxt;
      saved_r <= saved_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/tcw_queue.sv */
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module tcw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  tcw_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output tcw_pkg::cmd_t      head_cmd
);
  import tcw_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/tcw_back.sv */
// Back part: cursor, screen store with rotating top row, scroll, clear and read.
`timescale 1ns / 1ps
`default_nettype none
module tcw_back #(
  parameter int ROWS_N = tcw_pkg::ROWS_N_DEF,
  parameter int COLS_N = tcw_pkg::COLS_N_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  tcw_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [4:0]         out_cursor_row,
  output logic [6:0]         out_cursor_col,
  output logic [7:0]         out_current_color,
  output logic [15:0]        out_cell_value,
  output logic [1:0]         out_escape_pending
);
  import tcw_pkg::*;

  localparam int RW    = $clog2(ROWS_N);
  localparam int CW    = $clog2(COLS_N);
  localparam int DEPTH = ROWS_N * COLS_N;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS_N - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS_N - 1);
  localparam logic [RW:0]   ROWS_X    = (RW + 1)'(ROWS_N);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // The logical row is offset by the physical top row, so a scroll only
  // moves the top pointer and blanks one row.
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col,
                                              input logic [RW-1:0] top);
    logic [RW:0] p;
    p = {1'b0, row} + {1'b0, top};
    if (p >= ROWS_X) begin
      p = p - ROWS_X;
    end
    return AW'(32'(p) * COLS_N + 32'(col));
  endfunction

  function automatic logic in_range(input logic [4:0] rrow, input logic [6:0] rcol);
    return (32'(rrow) < ROWS_N) && (32'(rcol) < COLS_N);
  endfunction

  logic [15:0] mem_r [DEPTH];
  logic [15:0] rd_data_r;

  back_state_t   state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] top_r, top_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic          chi_r, chi_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [AW-1:0] limit_r, limit_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic [7:0]    out_color_r, out_color_nxt;
  logic [15:0]   out_cell_r, out_cell_nxt;
  logic [1:0]    out_esc_r, out_esc_nxt;

  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic [AW-1:0] ra;
  logic          finish;
  logic [15:0]   cell_fin;
  logic [7:0]    cur_ch;
  logic          more;
  logic          adv_row;

  assign init_busy          = (state_r == BK_INIT);
  assign out_valid          = out_valid_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_col     = out_col_r;
  assign out_current_color  = out_color_r;
  assign out_cell_value     = out_cell_r;
  assign out_escape_pending = out_esc_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    cmd_nxt       = cmd_r;
    chi_nxt       = chi_r;
    sweep_nxt     = sweep_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_color_nxt = out_color_r;
    out_cell_nxt  = out_cell_r;
    out_esc_nxt   = out_esc_r;
    we            = 1'b0;
    wa            = sweep_r;
    wd            = {cmd_r.color, CH_SPACE};
    ra            = '0;
    q_pop         = 1'b0;
    finish        = 1'b0;
    cell_fin      = '0;
    adv_row       = 1'b0;
    cur_ch        = chi_r ? cmd_r.ch1 : cmd_r.ch0;
    more          = !chi_r && cmd_r.two;
    case (state_r)
      BK_INIT: begin
        we = 1'b1;
        wd = BLANK_RESET;
        if (sweep_r == limit_r) begin
          state_nxt = BK_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (in_range(q_cmd.rrow, q_cmd.rcol)) begin
          ra = cell_addr(RW'(q_cmd.rrow), CW'(q_cmd.rcol), top_r);
        end
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          chi_nxt = 1'b0;
          case (q_cmd.op)
            OP_PRINT: state_nxt = BK_EMIT;
            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              sweep_nxt = '0;
              limit_nxt = LAST_ADDR;
              state_nxt = BK_CLEAR;
            end
            OP_READ:  state_nxt = BK_READ;
            default:  finish = 1'b1;
          endcase
        end
      end
      BK_EMIT: begin
        if (cur_ch == CH_LF) begin
          col_nxt = '0;
          adv_row = 1'b1;
        end else if (cur_ch == CH_BS) begin
          if (col_r != '0) begin
            col_nxt = col_r - 1'b1;
          end else if (row_r != '0) begin
            row_nxt = row_r - 1'b1;
            col_nxt = LAST_COL;
          end
          we = 1'b1;
          wa = cell_addr(row_nxt, col_nxt, top_r);
        end else begin
          we = 1'b1;
          wa = cell_addr(row_r, col_r, top_r);
          wd = {cmd_r.color, cur_ch};
          if (col_r == LAST_COL) begin
            col_nxt = '0;
            adv_row = 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        if (adv_row && row_r == LAST_ROW) begin
          // The old top row becomes the new bottom row and is blanked.
          top_nxt   = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
          sweep_nxt = cell_addr('0, '0, top_r);
          limit_nxt = cell_addr('0, LAST_COL, top_r);
          state_nxt = BK_SCROLL;
        end else begin
          if (adv_row) begin
            row_nxt = row_r + 1'b1;
          end
          if (more) begin
            chi_nxt = 1'b1;
          end else begin
            finish    = 1'b1;
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_SCROLL: begin
        we = 1'b1;
        if (sweep_r == limit_r) begin
          if (more) begin
            chi_nxt   = 1'b1;
            state_nxt = BK_EMIT;
          end else begin
            finish    = 1'b1;
            state_nxt = BK_IDLE;
          end
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      BK_CLEAR: begin
        we = 1'b1;
        if (sweep_r == limit_r) begin
          finish    = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      BK_READ: begin
        finish    = 1'b1;
        cell_fin  = in_range(cmd_r.rrow, cmd_r.rcol) ? rd_data_r : 16'h0000;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = 5'(row_nxt);
      out_col_nxt   = 7'(col_nxt);
      out_color_nxt = cmd_nxt.color;
      out_cell_nxt  = cell_fin;
      out_esc_nxt   = cmd_nxt.esc;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_data_r <= mem_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      chi_r       <= 1'b0;
      sweep_r     <= '0;
      limit_r     <= LAST_ADDR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      chi_r       <= chi_nxt;
      sweep_r     <= sweep_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_color_r <= out_color_nxt;
    out_cell_r  <= out_cell_nxt;
    out_esc_r   <= out_esc_nxt;
  end

endmodule
`default_nettype wire

/* rtl/text_console_writer_top.sv */
// Top level of the text console writer: front parser, command queue, back engine.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    mode, char code, string flags, color, cell
//   out_     output     out_valid / out_ready  cursor, color, cell value, escape phase
//
// After reset the back engine blanks the store with in_ready low.
// An item enters a two-entry queue; the back engine takes one item at a time.
// A printed character or control byte passes through the emit state, a second printed byte of
// the same item through it once more, and a read through the read state; a scroll blanks
// one row and a clear the whole store, through the single write port of the screen store.
// A waiting result stalls the back engine while the queue still accepts items.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_top #(
  parameter int ROWS_N = tcw_pkg::ROWS_N_DEF,
  parameter int COLS_N = tcw_pkg::COLS_N_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_first_of_string,
  input  wire logic        in_last_of_string,
  input  wire logic [7:0]  in_color_value,
  input  wire logic [4:0]  in_read_row,
  input  wire logic [6:0]  in_read_col,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_cursor_row,
  output logic [6:0]       out_cursor_col,
  output logic [7:0]       out_current_color,
  output logic [15:0]      out_cell_value,
  output logic [1:0]       out_escape_pending
);
  import tcw_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic head_valid;
  logic pop;
  logic init_busy;

  tcw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_char_code       (in_char_code),
    .in_first_of_string (in_first_of_string),
    .in_last_of_string  (in_last_of_string),
    .in_color_value     (in_color_value),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .q_full             (q_full),
    .init_busy          (init_busy),
    .push               (push),
    .cmd                (push_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcw_back #(
    .ROWS_N (ROWS_N),
    .COLS_N (COLS_N)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (head_valid),
    .q_cmd              (head_cmd),
    .q_pop              (pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_current_color  (out_current_color),
    .out_cell_value     (out_cell_value),
    .out_escape_pending (out_escape_pending)
  );

endmodule
`default_nettype wire
